>>> hdl/fvn_pkg.sv
// Shared types and constants for the fractal value noise block.
`timescale 1ns / 1ps

package fvn_pkg;

  // Register stages in one octave slice.
  localparam int unsigned OCT_STAGES = 11;

  // Quotient bits of the final normalizing divider (result may reach 65536).
  localparam int unsigned QUOT_W = 17;

  // Lattice hash multipliers.
  localparam logic [31:0] HASH_MUL_X    = 32'h8da6_b343;
  localparam logic [31:0] HASH_MUL_Y    = 32'hd816_3841;
  localparam logic [31:0] HASH_MUL_SEED = 32'hcb1a_b31f;
  localparam logic [31:0] HASH_MUL_FIN  = 32'h85eb_ca6b;

  // Full-scale 24-bit hash and half of (full scale << 8) for rounding.
  localparam logic [23:0] HASH_FULL  = 24'hff_ffff;
  localparam logic [31:0] HASH_ROUND = 32'h7fff_ff80;

  // Seed step between octaves.
  localparam int unsigned SEED_STEP = 1013;

  // Q1.16 one, Q0.16 half and Q0.16 saturation.
  localparam logic [16:0] AMP_ONE    = 17'd65536;
  localparam logic [15:0] NOISE_HALF = 16'd32768;
  localparam logic [15:0] NOISE_MAX  = 16'd65535;

  // Per-item fields carried down the octave chain.
  typedef struct packed {
    logic [47:0] coord_x;
    logic [47:0] coord_y;
    logic [15:0] pers;
    logic [31:0] base;
  } item_t;

endpackage

>>> hdl/fvn_octave.sv
// One pipelined octave slice: lattice hash, smoothstep blend and weighted accumulate.
`timescale 1ns / 1ps

module fvn_octave #(
  parameter int unsigned K               = 0,
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned NW              = 4,
  parameter int unsigned TOT_W           = 44,
  parameter int unsigned NORM_W          = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  fvn_pkg::item_t        in_item_i,
  input  logic [NW-1:0]         in_n_i,
  input  logic [TOT_W-1:0]      in_total_i,
  input  logic [NORM_W-1:0]     in_norm_i,
  input  logic [16:0]           in_amp_i,
  output logic                  out_valid_o,
  output fvn_pkg::item_t        out_item_o,
  output logic [NW-1:0]         out_n_o,
  output logic [TOT_W-1:0]      out_total_o,
  output logic [NORM_W-1:0]     out_norm_o,
  output logic [16:0]           out_amp_o
);

  localparam int unsigned NSTG     = fvn_pkg::OCT_STAGES;
  localparam logic [31:0] SEED_ADD = 32'(K * fvn_pkg::SEED_STEP);
  localparam logic [24:0] FULL1    = {1'b0, fvn_pkg::HASH_FULL};
  localparam logic [24:0] FULL2    = {fvn_pkg::HASH_FULL, 1'b0};

  // xor-fold of the three lattice products
  function automatic logic [31:0] mix3(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c);
    logic [31:0] h;
    h = a ^ b ^ c;
    return h ^ (h >> 13);
  endfunction

  // Carried fields, one entry per stage
  logic              dl_valid_q [NSTG];
  fvn_pkg::item_t    dl_item_q  [NSTG];
  logic [NW-1:0]     dl_n_q     [NSTG];
  logic [TOT_W-1:0]  dl_total_q [NSTG];
  logic [NORM_W-1:0] dl_norm_q  [NSTG];
  logic [16:0]       dl_amp_q   [NSTG];

  // Coordinate split (shift by K is wiring)
  logic [63:0] sc_x, sc_y;
  logic [15:0] tx_d, ty_d;
  assign sc_x = {{16{in_item_i.coord_x[47]}}, in_item_i.coord_x} << K;
  assign sc_y = {{16{in_item_i.coord_y[47]}}, in_item_i.coord_y} << K;

  if (COORD_FRAC_BITS >= 16) begin : g_frac_trunc
    assign tx_d = sc_x[COORD_FRAC_BITS-1 -: 16];
    assign ty_d = sc_y[COORD_FRAC_BITS-1 -: 16];
  end else begin : g_frac_pad
    assign tx_d = {sc_x[COORD_FRAC_BITS-1:0], {(16-COORD_FRAC_BITS){1'b0}}};
    assign ty_d = {sc_y[COORD_FRAC_BITS-1:0], {(16-COORD_FRAC_BITS){1'b0}}};
  end

  // Stage payload registers
  logic [31:0] x0_q, y0_q, seed_q;
  logic [15:0] tx_q, ty_q;
  logic [31:0] px0_q, px1_q, py0_q, py1_q, ps_q, ttx_q, tty_q;
  logic [17:0] ux_q, uy_q;
  logic [31:0] g_q [4];
  logic [49:0] pxs_q, pys_q;
  logic [31:0] m_q [4];
  logic [16:0] sx3_q, sy3_q, sx4_q, sy4_q, sy5_q;
  logic [23:0] h_q [4];
  logic [40:0] a_q, b_q;
  logic [56:0] v_q;
  logic [47:0] z_q;
  logic [24:0] val_q;
  logic [40:0] prod_q;
  logic [32:0] ampm_q;

  // Blend weights and correction for the division by full scale
  logic [16:0] wx, wy;
  logic [23:0] zq;
  logic [24:0] zr;
  logic [24:0] val_d;
  logic        oct_en;
  logic [16:0] amp_next;

  assign wx = fvn_pkg::AMP_ONE - sx4_q;
  assign wy = fvn_pkg::AMP_ONE - sy5_q;
  assign zq = z_q[47:24];
  assign zr = 25'(z_q[23:0]) + 25'(zq);
  always_comb begin
    val_d = 25'(zq);
    if (zr >= FULL2) begin
      val_d = 25'(zq) + 25'd2;
    end else if (zr >= FULL1) begin
      val_d = 25'(zq) + 25'd1;
    end
  end
  assign oct_en   = 32'(dl_n_q[NSTG-2]) > 32'(K);
  assign amp_next = 17'((ampm_q + 33'd32768) >> 16);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) dl_valid_q[s] <= 1'b0;
    end else begin
      dl_valid_q[0] <= in_valid_i;
      for (int s = 1; s < NSTG; s++) dl_valid_q[s] <= dl_valid_q[s-1];
    end
  end

  // Carried fields; the last entry takes this octave's contribution
  always_ff @(posedge clk_i) begin
    dl_item_q[0]  <= in_item_i;
    dl_n_q[0]     <= in_n_i;
    dl_total_q[0] <= in_total_i;
    dl_norm_q[0]  <= in_norm_i;
    dl_amp_q[0]   <= in_amp_i;
    for (int s = 1; s < NSTG; s++) begin
      dl_item_q[s] <= dl_item_q[s-1];
      dl_n_q[s]    <= dl_n_q[s-1];
    end
    for (int s = 1; s < NSTG - 1; s++) begin
      dl_total_q[s] <= dl_total_q[s-1];
      dl_norm_q[s]  <= dl_norm_q[s-1];
      dl_amp_q[s]   <= dl_amp_q[s-1];
    end
    if (oct_en) begin
      dl_total_q[NSTG-1] <= dl_total_q[NSTG-2] + TOT_W'(prod_q);
      dl_norm_q[NSTG-1]  <= dl_norm_q[NSTG-2] + NORM_W'(dl_amp_q[NSTG-2]);
      dl_amp_q[NSTG-1]   <= amp_next;
    end else begin
      dl_total_q[NSTG-1] <= dl_total_q[NSTG-2];
      dl_norm_q[NSTG-1]  <= dl_norm_q[NSTG-2];
      dl_amp_q[NSTG-1]   <= dl_amp_q[NSTG-2];
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    // cell, fraction, octave seed
    x0_q   <= sc_x[COORD_FRAC_BITS +: 32];
    y0_q   <= sc_y[COORD_FRAC_BITS +: 32];
    tx_q   <= tx_d;
    ty_q   <= ty_d;
    seed_q <= in_item_i.base + SEED_ADD;
    // lattice products, t*t and 3-2t
    px0_q <= x0_q * fvn_pkg::HASH_MUL_X;
    px1_q <= (x0_q + 32'd1) * fvn_pkg::HASH_MUL_X;
    py0_q <= y0_q * fvn_pkg::HASH_MUL_Y;
    py1_q <= (y0_q + 32'd1) * fvn_pkg::HASH_MUL_Y;
    ps_q  <= seed_q * fvn_pkg::HASH_MUL_SEED;
    ttx_q <= 32'(tx_q) * 32'(tx_q);
    tty_q <= 32'(ty_q) * 32'(ty_q);
    ux_q  <= 18'd196608 - {1'b0, tx_q, 1'b0};
    uy_q  <= 18'd196608 - {1'b0, ty_q, 1'b0};
    // corner fold, smoothstep product
    g_q[0] <= mix3(px0_q, py0_q, ps_q);
    g_q[1] <= mix3(px1_q, py0_q, ps_q);
    g_q[2] <= mix3(px0_q, py1_q, ps_q);
    g_q[3] <= mix3(px1_q, py1_q, ps_q);
    pxs_q  <= 50'(ttx_q) * 50'(ux_q);
    pys_q  <= 50'(tty_q) * 50'(uy_q);
    // final hash multiply, smoothstep rounding
    for (int i = 0; i < 4; i++) m_q[i] <= g_q[i] * fvn_pkg::HASH_MUL_FIN;
    sx3_q <= 17'((pxs_q + 50'd2147483648) >> 32);
    sy3_q <= 17'((pys_q + 50'd2147483648) >> 32);
    // hash fractions
    for (int i = 0; i < 4; i++) h_q[i] <= 24'(m_q[i] ^ (m_q[i] >> 16));
    sx4_q <= sx3_q;
    sy4_q <= sy3_q;
    // blend along x
    a_q   <= 41'(h_q[0]) * 41'(wx) + 41'(h_q[1]) * 41'(sx4_q);
    b_q   <= 41'(h_q[2]) * 41'(wx) + 41'(h_q[3]) * 41'(sx4_q);
    sy5_q <= sy4_q;
    // blend along y
    v_q <= 57'(a_q) * 57'(wy) + 57'(b_q) * 57'(sy5_q);
    // round and drop the << 8 part of the full-scale divisor
    z_q <= 48'((v_q + 57'(fvn_pkg::HASH_ROUND)) >> 8);
    // divide by full scale with one correction step
    val_q <= val_d;
    // weight by amplitude, next amplitude
    prod_q <= 41'(val_q) * 41'(dl_amp_q[NSTG-3]);
    ampm_q <= 33'(dl_amp_q[NSTG-3]) * 33'(dl_item_q[NSTG-3].pers);
  end

  assign out_valid_o = dl_valid_q[NSTG-1];
  assign out_item_o  = dl_item_q[NSTG-1];
  assign out_n_o     = dl_n_q[NSTG-1];
  assign out_total_o = dl_total_q[NSTG-1];
  assign out_norm_o  = dl_norm_q[NSTG-1];
  assign out_amp_o   = dl_amp_q[NSTG-1];

endmodule

>>> hdl/fvn_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module fvn_div #(
  parameter int unsigned NUM_W = 45,
  parameter int unsigned DEN_W = 28,
  parameter int unsigned Q_W   = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_zero_i,
  input  logic [NUM_W-1:0] in_num_i,
  input  logic [DEN_W-1:0] in_den_i,
  output logic             out_valid_o,
  output logic             out_zero_o,
  output logic [Q_W-1:0]   out_quot_o
);

  localparam int unsigned REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             valid_q [Q_W];
  logic             zero_q  [Q_W];
  logic [REM_W-1:0] rem_q   [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [Q_W-1:0]   quot_q  [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int unsigned I = Q_W - 1 - j;
    logic             v_in, z_in;
    logic [REM_W-1:0] r_in, sh;
    logic [DEN_W-1:0] d_in;
    logic [Q_W-1:0]   q_in, q_out;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in = in_valid_i;
      assign z_in = in_zero_i;
      assign r_in = REM_W'(in_num_i);
      assign d_in = in_den_i;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = valid_q[j-1];
      assign z_in = zero_q[j-1];
      assign r_in = rem_q[j-1];
      assign d_in = den_q[j-1];
      assign q_in = quot_q[j-1];
    end

    // trial subtract of the shifted divisor
    assign sh = REM_W'(d_in) << I;
    assign ge = r_in >= sh;
    always_comb begin
      q_out    = q_in;
      q_out[I] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[j] <= z_in;
      den_q[j]  <= d_in;
      quot_q[j] <= q_out;
      rem_q[j]  <= ge ? r_in - sh : r_in;
    end
  end

  assign out_valid_o = valid_q[Q_W-1];
  assign out_zero_o  = zero_q[Q_W-1];
  assign out_quot_o  = quot_q[Q_W-1];

endmodule

>>> hdl/fractal_value_noise_2d.sv
// Top level of the fractal value noise block: octave chain, normalize, output.
`timescale 1ns / 1ps

// Fractal value noise over a 2D point. The block is fully pipelined and takes a
// new word on every cycle that start is high; busy never rises. Each result
// appears on noise_value_o with done_o high for one cycle once its word has
// passed through eleven stages per octave slice, one stage to form the
// normalizing division, seventeen divider stages (one quotient bit each) and the
// output register. The latency does not depend on octave_count. Results come
// out in start order and cannot be held off. noise_seed is written through the
// cfg channel, which is always ready; write it only while no word is in flight.

module fractal_value_noise_2d #(
  parameter int unsigned MAX_OCTAVES     = 8,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [47:0] coord_x_i,
  input  logic signed [47:0] coord_y_i,
  input  logic [3:0]         octave_count_i,
  input  logic [15:0]        persistence_i,
  input  logic signed [31:0] seed_offset_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [31:0] cfg_data_i,
  output logic               done_o,
  output logic [15:0]        noise_value_o
);

  localparam int unsigned NW     = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned LOG_O  = $clog2(MAX_OCTAVES);
  localparam int unsigned TOT_W  = 41 + LOG_O;
  localparam int unsigned NORM_W = 17 + LOG_O;
  localparam int unsigned NUM_W  = TOT_W + 1;
  localparam int unsigned DEN_W  = NORM_W + 8;
  localparam int unsigned Q_W    = fvn_pkg::QUOT_W;

  // Seed register
  logic [31:0] noise_seed_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      noise_seed_q <= cfg_data_i;
    end
  end

  // Octave chain links
  logic              ch_valid [MAX_OCTAVES+1];
  fvn_pkg::item_t    ch_item  [MAX_OCTAVES+1];
  logic [NW-1:0]     ch_n     [MAX_OCTAVES+1];
  logic [TOT_W-1:0]  ch_total [MAX_OCTAVES+1];
  logic [NORM_W-1:0] ch_norm  [MAX_OCTAVES+1];
  logic [16:0]       ch_amp   [MAX_OCTAVES+1];

  // Incoming word, octave count saturated
  assign ch_valid[0]         = start && !busy;
  assign ch_item[0].coord_x  = coord_x_i;
  assign ch_item[0].coord_y  = coord_y_i;
  assign ch_item[0].pers     = persistence_i;
  assign ch_item[0].base     = noise_seed_q + seed_offset_i;
  assign ch_n[0]     = (32'(octave_count_i) > 32'(MAX_OCTAVES)) ? NW'(MAX_OCTAVES)
                                                                 : NW'(octave_count_i);
  assign ch_total[0] = '0;
  assign ch_norm[0]  = '0;
  assign ch_amp[0]   = fvn_pkg::AMP_ONE;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fvn_octave #(
      .K               (k),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .NW              (NW),
      .TOT_W           (TOT_W),
      .NORM_W          (NORM_W)
    ) u_oct (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (ch_valid[k]),
      .in_item_i   (ch_item[k]),
      .in_n_i      (ch_n[k]),
      .in_total_i  (ch_total[k]),
      .in_norm_i   (ch_norm[k]),
      .in_amp_i    (ch_amp[k]),
      .out_valid_o (ch_valid[k+1]),
      .out_item_o  (ch_item[k+1]),
      .out_n_o     (ch_n[k+1]),
      .out_total_o (ch_total[k+1]),
      .out_norm_o  (ch_norm[k+1]),
      .out_amp_o   (ch_amp[k+1])
    );
  end

  // Rounded division operands: (total + norm*128) / (norm*256)
  logic             dv_valid_q, dv_zero_q;
  logic [NUM_W-1:0] dv_num_q;
  logic [DEN_W-1:0] dv_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q <= 1'b0;
    end else begin
      dv_valid_q <= ch_valid[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_zero_q <= ch_n[MAX_OCTAVES] == '0;
    dv_num_q  <= NUM_W'(ch_total[MAX_OCTAVES]) + (NUM_W'(ch_norm[MAX_OCTAVES]) << 7);
    dv_den_q  <= DEN_W'(ch_norm[MAX_OCTAVES]) << 8;
  end

  logic           qt_valid, qt_zero;
  logic [Q_W-1:0] qt_quot;

  fvn_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid_q),
    .in_zero_i   (dv_zero_q),
    .in_num_i    (dv_num_q),
    .in_den_i    (dv_den_q),
    .out_valid_o (qt_valid),
    .out_zero_o  (qt_zero),
    .out_quot_o  (qt_quot)
  );

  // Output register: zero octaves give one half, full scale saturates
  logic        done_q;
  logic [15:0] noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= qt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qt_zero) begin
      noise_q <= fvn_pkg::NOISE_HALF;
    end else if (qt_quot > Q_W'(fvn_pkg::NOISE_MAX)) begin
      noise_q <= fvn_pkg::NOISE_MAX;
    end else begin
      noise_q <= qt_quot[15:0];
    end
  end

  assign done_o        = done_q;
  assign noise_value_o = noise_q;

endmodule
